@@ rtl/core/msort_pkg.sv @@
// Shared constants, item types and controller/datapath interface structs for the merge sorter.
package msort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_in;
        logic                     last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     last_out;
    } out_item_t;

    typedef struct packed {
        logic load;        // store the accepted item
        logic pass_setup;  // initialize pointers for a merge pass
        logic merge;       // move one element into the destination buffer
        logic emit_setup;  // point the read port at the first sorted element
        logic emit_step;   // advance to the next sorted element
    } msort_cmd_t;

    typedef struct packed {
        logic sorted;      // run width has reached the set size
        logic pass_end;    // this merge step writes the last element of the pass
        logic emit_last;   // the element on the output is the final one
    } msort_status_t;

endpackage

@@ rtl/core/msort_dp.sv @@
// Datapath of the merge sorter: two ping-pong buffers, merge pointers and the output read.
module msort_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msort_pkg::msort_cmd_t cmd,
    input  msort_pkg::in_item_t  s_item,
    output msort_pkg::msort_status_t status,
    output msort_pkg::out_item_t m_item
);
    import msort_pkg::*;

    logic [DATA_W-1:0] mem_a [MAX_ITEMS];
    logic [DATA_W-1:0] mem_b [MAX_ITEMS];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic              src_sel_reg, src_sel_next;   // 0: buffer A holds the runs
    logic [CNT_W-1:0]  li_reg, li_next;
    logic [CNT_W-1:0]  ri_reg, ri_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [DATA_W-1:0] rd_l_reg, rd_r_reg;

    logic              left_ok, right_ok, take_r, seg_end, has_room;
    logic [CNT_W:0]    hi_plus_w, hi_plus_2w, two_w;
    logic [DATA_W-1:0] merge_data;
    logic              wr_a_en, wr_b_en;
    logic [ADDR_W-1:0] wr_a_addr;
    logic [DATA_W-1:0] wr_a_data;

    // Clamp a run boundary to the set size.
    function automatic logic [CNT_W-1:0] clamp_n(input logic [CNT_W:0] v,
                                                  input logic [CNT_W-1:0] n);
        clamp_n = (v > {1'b0, n}) ? n : v[CNT_W-1:0];
    endfunction

    assign has_room   = (cnt_reg < CNT_W'(MAX_ITEMS));
    assign left_ok    = (li_reg < mid_reg);
    assign right_ok   = (ri_reg < hi_reg);
    // On a tie the right run goes first.
    assign take_r     = !left_ok ||
                        (right_ok && !($signed(rd_l_reg) < $signed(rd_r_reg)));
    assign merge_data = take_r ? rd_r_reg : rd_l_reg;
    assign seg_end    = ((k_reg + CNT_W'(1)) == hi_reg);
    assign two_w      = {w_reg, 1'b0};
    assign hi_plus_w  = {1'b0, hi_reg} + {1'b0, w_reg};
    assign hi_plus_2w = {1'b0, hi_reg} + two_w;

    assign status.sorted    = (w_reg >= n_reg);
    assign status.pass_end  = ((k_reg + CNT_W'(1)) == n_reg);
    assign status.emit_last = (({1'b0, li_reg} + (CNT_W+1)'(1)) == {1'b0, n_reg});

    assign m_item.value_out = rd_l_reg;
    assign m_item.last_out  = status.emit_last;

    always_comb begin
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        w_next       = w_reg;
        src_sel_next = src_sel_reg;
        li_next      = li_reg;
        ri_next      = ri_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;

        if (cmd.load) begin
            cnt_next = cnt_reg + CNT_W'(has_room);
            if (s_item.last_in) begin
                n_next       = cnt_reg + CNT_W'(has_room);
                cnt_next     = '0;
                w_next       = CNT_W'(1);
                src_sel_next = 1'b0;
            end
        end
        if (cmd.pass_setup) begin
            k_next   = '0;
            li_next  = '0;
            mid_next = clamp_n({1'b0, w_reg}, n_reg);
            ri_next  = clamp_n({1'b0, w_reg}, n_reg);
            hi_next  = clamp_n(two_w, n_reg);
        end
        if (cmd.merge) begin
            k_next  = k_reg + CNT_W'(1);
            li_next = li_reg + CNT_W'(!take_r);
            ri_next = ri_reg + CNT_W'(take_r);
            if (status.pass_end) begin
                w_next       = two_w[CNT_W-1:0];
                src_sel_next = !src_sel_reg;
            end else if (seg_end) begin
                li_next  = hi_reg;
                mid_next = clamp_n(hi_plus_w, n_reg);
                ri_next  = clamp_n(hi_plus_w, n_reg);
                hi_next  = clamp_n(hi_plus_2w, n_reg);
            end
        end
        if (cmd.emit_setup) begin
            li_next = '0;
        end
        if (cmd.emit_step) begin
            li_next = li_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            n_reg       <= '0;
            w_reg       <= CNT_W'(1);
            src_sel_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            w_reg       <= w_next;
            src_sel_reg <= src_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        li_reg  <= li_next;
        ri_reg  <= ri_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        k_reg   <= k_next;
    end

    // Buffer A takes loaded items; merge passes write whichever buffer is not the source.
    assign wr_a_en   = (cmd.load && has_room) || (cmd.merge && src_sel_reg);
    assign wr_b_en   = cmd.merge && !src_sel_reg;
    assign wr_a_addr = cmd.load ? cnt_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign wr_a_data = cmd.load ? s_item.value_in : merge_data;

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            mem_a[wr_a_addr] <= wr_a_data;
        end
        if (wr_b_en) begin
            mem_b[k_reg[ADDR_W-1:0]] <= merge_data;
        end
        rd_l_reg <= src_sel_reg ? mem_b[li_next[ADDR_W-1:0]] : mem_a[li_next[ADDR_W-1:0]];
        rd_r_reg <= src_sel_reg ? mem_b[ri_next[ADDR_W-1:0]] : mem_a[ri_next[ADDR_W-1:0]];
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count exceeds capacity");

    a_width_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(w_reg))
        else $error("run width is not a power of two");

    a_merge_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge |-> (k_reg < n_reg) && (left_ok || right_ok))
        else $error("merge step outside the set or with both runs empty");

    a_emit_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_step |-> (li_reg < n_reg))
        else $error("emit index outside the set");

endmodule

@@ rtl/core/msort_ctrl.sv @@
// Controller state machine of the merge sorter: load, merge passes and emit.
module msort_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_last,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  msort_pkg::msort_status_t status,
    output msort_pkg::msort_cmd_t   cmd
);
    import msort_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                cmd.load = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (status.sorted) begin
                    cmd.emit_setup = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    cmd.pass_setup = 1'b1;
                    state_next     = ST_MERGE;
                end
            end
            ST_MERGE: begin
                cmd.merge = 1'b1;
                if (status.pass_end) begin
                    state_next = ST_SETUP;
                end
            end
            ST_EMIT: begin
                cmd.emit_step = m_ready;
                if (m_ready && status.emit_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    a_last_emit_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.emit_last) |=> s_ready)
        else $error("block did not return to loading after the final result");

endmodule

@@ rtl/core/merge_sorter.sv @@
// Top level of the merge sorter: controller and datapath joined by command and status.
//
// The block collects up to MAX_ITEMS (64) signed 32-bit values, one per accepted input
// item, until an item with last_in set closes the set; items arriving while the set is
// full are dropped, though a dropped item carrying last_in still closes the set. The set
// is then sorted ascending by a bottom-up merge sort and returned as one result item per
// value, with last_out set on the final one. When two values compare equal, the one from
// the right run leaves first. Sorting runs ceil(log2(n)) merge passes over two ping-pong
// buffers; each pass follows a setup step and moves one element per cycle through a single
// signed comparator, and a final setup step prepares the output read. Results then leave
// at one per cycle while m_ready is high. The input is not ready while a set is being
// sorted or emitted.
module merge_sorter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  msort_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output msort_pkg::out_item_t m_item
);
    import msort_pkg::*;

    msort_cmd_t    cmd;
    msort_status_t status;

    // The controller sequences loading, merge passes and output; it never touches data.
    msort_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_item.last_in),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds both buffers, the run pointers and the registered output value.
    msort_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .status  (status),
        .m_item  (m_item)
    );

endmodule

@@ tb/sv/merge_sorter_test.sv @@
// Self-checking testbench for merge_sorter: random sets in, sorted results checked in order.
`timescale 1ns / 100ps

module merge_sorter_test;
    import msort_pkg::*;

    // Traffic phases. Each one sets how often the sender idles and the receiver
    // stalls. The hold phase adds one long receiver hold-off at its start.
    typedef enum {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} traffic_e;

    // Value styles for a set: full 32-bit range, a narrow band that forces
    // repeated values, or the corner values of the signed range.
    typedef enum {VAL_WIDE, VAL_NARROW, VAL_EDGE} value_style_e;

    localparam int HOLD_CYCLES  = 1000;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 50;
    localparam int MAX_REPORTS  = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    traffic_e phase = PH_FREE;

    // Items waiting to be offered, values of the set now being loaded, and the
    // sorted results that the block still owes us.
    in_item_t                 pending[$];
    logic signed [DATA_W-1:0] open_set[$];
    out_item_t                sorted_due[$];

    int fail_count = 0;
    int result_idx = 0;
    int quiet_cycles;
    int hold_left;
    traffic_e last_phase;

    merge_sorter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Predictor. An accepted item joins the open set unless the set is full;
    // an item marked last closes the set, even if its own value was dropped.
    // The closed set is sorted ascending and queued as the expected results.
    // Equal values cannot be told apart at the output, so the tie rule of the
    // block does not change what we expect.
    function automatic void absorb_item(in_item_t it);
        int i;
        int j;
        logic signed [DATA_W-1:0] key;
        out_item_t res;
        if (open_set.size() < MAX_ITEMS) begin
            open_set.push_back(it.value_in);
        end
        if (it.last_in) begin
            for (i = 1; i < open_set.size(); i++) begin
                key = open_set[i];
                j = i - 1;
                while (j >= 0 && open_set[j] > key) begin
                    open_set[j + 1] = open_set[j];
                    j--;
                end
                open_set[j + 1] = key;
            end
            for (i = 0; i < open_set.size(); i++) begin
                res.value_out = open_set[i];
                res.last_out  = (i == open_set.size() - 1);
                sorted_due.push_back(res);
            end
            open_set.delete();
        end
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // Driver. The predictor sees each item at the edge where it is accepted.
    // A new item is only chosen when the channel is empty or has just moved,
    // so valid and payload hold steady while the block stalls.
    always @(posedge aclk) begin : drive
        int gap_pct;
        gap_pct = (phase == PH_SEND_IDLE) ? 47 : (phase == PH_BOTH) ? 14 : 0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_item(s_item);
            end
            if (!s_valid || s_ready) begin
                if (pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    s_item  <= pending.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each result is checked against the oldest expectation. On entry
    // to the hold phase the receiver holds off for a long stretch, so the block
    // finishes its sort, sits on its first result and keeps its input closed.
    always @(posedge aclk) begin : collect
        int stall_pct;
        out_item_t want;
        stall_pct = (phase == PH_RECV_STALL) ? 47 : (phase == PH_BOTH) ? 14 : 0;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            last_phase <= PH_FREE;
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_due.size() == 0) begin
                    note_failure($sformatf("unexpected result %0d: value %0d last %0b",
                        result_idx, m_item.value_out, m_item.last_out));
                end else begin
                    want = sorted_due.pop_front();
                    if (m_item.value_out !== want.value_out) begin
                        note_failure($sformatf("result %0d value: expected %0d, got %0d",
                            result_idx, want.value_out, m_item.value_out));
                    end
                    if (m_item.last_out !== want.last_out) begin
                        note_failure($sformatf("result %0d last flag: expected %0b, got %0b",
                            result_idx, want.last_out, m_item.last_out));
                    end
                end
                result_idx++;
            end
            last_phase <= phase;
            if (phase == PH_HOLD && last_phase != PH_HOLD) begin
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves an item
    // means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("merge_sorter: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value(value_style_e style);
        case (style)
            VAL_NARROW: return int'($urandom_range(8)) - 4;
            VAL_EDGE: begin
                case ($urandom_range(6))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    4: return 32'h0000_0001;
                    5: return 32'h8000_0001;
                    default: return 32'h7fff_fffe;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_value(logic signed [DATA_W-1:0] v, logic closes);
        in_item_t it;
        it.value_in = v;
        it.last_in  = closes;
        pending.push_back(it);
    endtask

    task automatic add_set(int n, value_style_e style);
        int k;
        for (k = 0; k < n; k++) begin
            push_value(pick_value(style), k == n - 1);
        end
    endtask

    // Random sets, mostly short. Now and then a long one, or one at or past
    // the capacity; past it, the trailing values, the closing one among them,
    // are dropped.
    task automatic add_random_sets(int n_items);
        int added;
        int n;
        int roll;
        added = 0;
        while (added < n_items) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                n = MAX_ITEMS + $urandom_range(4);
            end else if (roll < 15) begin
                n = $urandom_range(MAX_ITEMS - 1, 11);
            end else begin
                n = $urandom_range(10, 1);
            end
            add_set(n, value_style_e'($urandom_range(2)));
            added += n;
        end
    endtask

    // enter_phase switches the traffic phase at a clock edge and returns at the
    // falling edge, where stimulus is queued; wait_drained then waits until every
    // queued item is sent and the block has returned every result owed so far.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending.size() != 0 || s_valid || sorted_due.size() != 0);
    endtask

    task automatic enter_phase(traffic_e ph);
        @(posedge aclk);
        phase <= ph;
        @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        enter_phase(PH_FREE);
        // A set of one value.
        push_value(32'h7fff_ffff, 1'b1);
        // The corners of the signed range in mixed order.
        push_value(32'h0000_0000, 1'b0);
        push_value(32'hffff_ffff, 1'b0);
        push_value(32'h8000_0000, 1'b0);
        push_value(32'h7fff_ffff, 1'b0);
        push_value(32'h0000_0001, 1'b1);
        // Repeated values, where the block takes the right run first on a tie.
        push_value(5, 1'b0);
        push_value(5, 1'b0);
        push_value(-5, 1'b0);
        push_value(5, 1'b0);
        push_value(-5, 1'b1);
        // Two values already in order, then the same two reversed.
        push_value(32'h8000_0000, 1'b0);
        push_value(32'h7fff_ffff, 1'b1);
        push_value(32'h7fff_ffff, 1'b0);
        push_value(32'h8000_0000, 1'b1);
        // Every value the same.
        push_value(-1, 1'b0);
        push_value(-1, 1'b0);
        push_value(-1, 1'b1);
        wait_drained();
        add_random_sets(30);
        wait_drained();

        enter_phase(PH_SEND_IDLE);
        add_random_sets(30);
        wait_drained();

        enter_phase(PH_RECV_STALL);
        add_random_sets(30);
        wait_drained();

        enter_phase(PH_BOTH);
        add_random_sets(30);
        wait_drained();

        // Long receiver hold-off with the sender pushing hard: an exactly full
        // set, an overflowing set closed by a dropped item, then random sets.
        enter_phase(PH_HOLD);
        add_set(MAX_ITEMS, VAL_WIDE);
        add_set(MAX_ITEMS + 3, VAL_NARROW);
        add_random_sets(10);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && sorted_due.size() == 0) begin
            $display("merge_sorter: match");
        end else begin
            $display("merge_sorter: mismatch");
        end
        $finish;
    end

endmodule

@@ merge_sorter.f @@
rtl/core/msort_pkg.sv
rtl/core/msort_dp.sv
rtl/core/msort_ctrl.sv
rtl/core/merge_sorter.sv
tb/sv/merge_sorter_test.sv
